// ===== hdl/text_console_writer_macros.svh =====
// Assertion macros for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define TCW_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TCW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/tcw_pkg.sv =====
// Types, codes and microcode table of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

   localparam logic [2:0] OP_PUT_CURSOR = 3'd0;
   localparam logic [2:0] OP_PUT_AT     = 3'd1;
   localparam logic [2:0] OP_BACKSPACE  = 3'd2;
   localparam logic [2:0] OP_CLEAR      = 3'd3;
   localparam logic [2:0] OP_READ       = 3'd4;

   localparam logic [7:0] CODE_NEWLINE        = 8'h0A;
   localparam logic [7:0] CODE_BLANK_IN_PLACE = 8'h08;
   localparam logic [7:0] CODE_ERROR          = 8'h45;
   localparam logic [7:0] CODE_SPACE          = 8'h20;

   localparam logic [1:0] REG_ZERO_ATTR_SUB = 2'd0;
   localparam logic [1:0] REG_ERROR_ATTR    = 2'd1;
   localparam logic [1:0] REG_CLEAR_ATTR    = 2'd2;

   localparam logic [7:0] RESET_ZERO_ATTR_SUB = 8'd31;
   localparam logic [7:0] RESET_ERROR_ATTR    = 8'd244;
   localparam logic [7:0] RESET_CLEAR_ATTR    = 8'd15;

   typedef logic [3:0] step_type;

   localparam step_type S_IDLE    = 4'd0;
   localparam step_type S_PUT     = 4'd1;
   localparam step_type S_BACK    = 4'd2;
   localparam step_type S_CLEAR   = 4'd3;
   localparam step_type S_READ    = 4'd4;
   localparam step_type S_RD_CAP  = 4'd5;
   localparam step_type S_SCR_RD  = 4'd6;
   localparam step_type S_SCR_WR  = 4'd7;
   localparam step_type S_ZERO    = 4'd8;
   localparam step_type S_DONE    = 4'd9;

   typedef enum logic [3:0] {
      A_NOP,
      A_PUT,
      A_BACK,
      A_CLEAR,
      A_READ,
      A_CAPTURE,
      A_SCR_RD,
      A_SCR_WR,
      A_ZERO,
      A_EMIT
   } act_type;

   typedef enum logic [2:0] {
      C_DISPATCH,
      C_ALWAYS,
      C_SCROLL,
      C_CNT_LAST,
      C_MOVE_LAST,
      C_RANGE_ERR,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type jump_t;
      step_type jump_f;
   } ucode_type;

   function automatic ucode_type ucode(input step_type step);
      ucode_type w;
      case (step)
         S_IDLE:   w = '{A_NOP,     C_DISPATCH,  S_IDLE,   S_IDLE};
         S_PUT:    w = '{A_PUT,     C_SCROLL,    S_SCR_RD, S_DONE};
         S_BACK:   w = '{A_BACK,    C_ALWAYS,    S_DONE,   S_DONE};
         S_CLEAR:  w = '{A_CLEAR,   C_CNT_LAST,  S_DONE,   S_CLEAR};
         S_READ:   w = '{A_READ,    C_RANGE_ERR, S_DONE,   S_RD_CAP};
         S_RD_CAP: w = '{A_CAPTURE, C_ALWAYS,    S_DONE,   S_DONE};
         S_SCR_RD: w = '{A_SCR_RD,  C_ALWAYS,    S_SCR_WR, S_SCR_WR};
         S_SCR_WR: w = '{A_SCR_WR,  C_MOVE_LAST, S_ZERO,   S_SCR_RD};
         S_ZERO:   w = '{A_ZERO,    C_CNT_LAST,  S_DONE,   S_ZERO};
         S_DONE:   w = '{A_EMIT,    C_OUT_FREE,  S_IDLE,   S_DONE};
         default:  w = '{A_NOP,     C_ALWAYS,    S_IDLE,   S_IDLE};
      endcase
      return w;
   endfunction

   function automatic step_type op_entry(input logic [2:0] op);
      step_type s;
      case (op)
         OP_PUT_CURSOR: s = S_PUT;
         OP_PUT_AT:     s = S_PUT;
         OP_BACKSPACE:  s = S_BACK;
         OP_CLEAR:      s = S_CLEAR;
         OP_READ:       s = S_READ;
         default:       s = S_DONE;
      endcase
      return s;
   endfunction

endpackage

// ===== hdl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/text_console_writer.sv =====
// Text console writer: microcoded sequencer over a character-cell RAM.
// Item to result: put and backspace act, then emit; read also captures RAM data (not when
// out of range); unused ops emit at once; clear first writes every cell. A put that passes
// the end scrolls first: each moved cell is read, then written, and the last row is zeroed.
// Throughput: one item at a time; the next is taken the cycle after a result is loaded.
// Sync reset clears cursor and sequencer, presets attributes; cell RAM undefined until written.
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   // tuser: op[2:0]
   // tdata: character[7:0], attribute[15:8], column[22:16], line[27:23],
   //        cell_index[38:28]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [2:0]  req_tuser,
   // tdata: cursor_cell[10:0], read_char[18:11], read_attr[26:19],
   //        coord_error[27]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int RW    = $clog2(ROWS);
   localparam int RW1   = $clog2(ROWS + 1);
   localparam int XW    = (AW + 1 > 12) ? AW + 1 : 12;

   // sequencer
   step_type  pc_ff, pc_in;
   ucode_type uw;
   logic      cond_hit;

   logic [AW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;

   logic [7:0] sub_ff, sub_in;
   logic [7:0] eattr_ff, eattr_in;
   logic [7:0] cattr_ff, cattr_in;

   // latched item
   logic [2:0]  op_ff, op_in;
   logic [7:0]  ch_ff, ch_in;
   logic [7:0]  at_ff, at_in;
   logic [6:0]  colq_ff, colq_in;
   logic [4:0]  lineq_ff, lineq_in;
   logic [10:0] idx_ff, idx_in;

   logic       err_ff, err_in;
   logic [7:0] rch_ff, rch_in;
   logic [7:0] rat_ff, rat_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   // datapath
   logic          req_acc;
   logic          out_free;
   logic          csr_wr;
   logic [AW-1:0] cur_idx;
   logic [XW-1:0] cur_x;
   logic [RW-1:0] t_row;
   logic [CW-1:0] t_col;
   logic [AW-1:0] tgt_addr;
   logic          tgt_bad;
   logic [7:0]    at_eff;
   logic [RW1-1:0] p_row1;
   logic [CW-1:0]  p_col;
   logic           p_wr;
   logic [15:0]    p_data;
   logic [AW-1:0]  p_addr;
   logic           p_scroll;
   logic [AW-1:0]  b_addr;
   logic [RW-1:0]  b_row;
   logic [CW-1:0]  b_col;
   logic           idx_ok;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [15:0]   rd_data;

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign uw         = ucode(pc_ff);
   assign req_tready = (pc_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign cur_idx  = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);
   assign cur_x    = XW'(cur_idx);
   assign tgt_bad  = (op_ff == OP_PUT_AT) &&
                     ((colq_ff >= 7'(COLUMNS)) || (lineq_ff >= 5'(ROWS)));
   assign t_row    = (op_ff == OP_PUT_CURSOR) ? row_ff : RW'(lineq_ff);
   assign t_col    = (op_ff == OP_PUT_CURSOR) ? col_ff : CW'(colq_ff);
   assign tgt_addr = AW'(t_row) * AW'(COLUMNS) + AW'(t_col);
   assign at_eff   = (at_ff == 8'd0) ? sub_ff : at_ff;
   assign idx_ok   = (XW'(idx_ff) < XW'(CELLS));

   always_comb begin
      p_wr   = 1'b0;
      p_addr = tgt_addr;
      p_data = {at_eff, ch_ff};
      p_row1 = RW1'(t_row);
      p_col  = t_col;
      if (tgt_bad) begin
         p_wr   = 1'b1;
         p_addr = AW'(CELLS - 1);
         p_data = {eattr_ff, CODE_ERROR};
         p_row1 = RW1'(row_ff);
         p_col  = col_ff;
      end else if (ch_ff == CODE_NEWLINE) begin
         p_row1 = RW1'(t_row) + RW1'(1);
         p_col  = '0;
      end else if (ch_ff == CODE_BLANK_IN_PLACE) begin
         p_wr   = 1'b1;
         p_data = {at_eff, CODE_SPACE};
      end else begin
         p_wr = 1'b1;
         if (t_col == CW'(COLUMNS - 1)) begin
            p_row1 = RW1'(t_row) + RW1'(1);
            p_col  = '0;
         end else begin
            p_col = t_col + CW'(1);
         end
      end
   end

   assign p_scroll = (p_row1 == RW1'(ROWS));

   always_comb begin
      b_addr = cur_idx - AW'(1);
      b_row  = row_ff;
      b_col  = col_ff - CW'(1);
      if (cur_idx == '0) begin
         b_addr = '0;
         b_col  = '0;
      end else if (col_ff == '0) begin
         b_row = row_ff - RW'(1);
         b_col = CW'(COLUMNS - 1);
      end
   end

   always_comb begin
      cond_hit = 1'b1;
      case (uw.cond)
         C_DISPATCH:  cond_hit = req_acc;
         C_ALWAYS:    cond_hit = 1'b1;
         C_SCROLL:    cond_hit = p_scroll;
         C_CNT_LAST:  cond_hit = (cnt_ff == AW'(CELLS - 1));
         C_MOVE_LAST: cond_hit = (cnt_ff == AW'(CELLS - COLUMNS - 1));
         C_RANGE_ERR: cond_hit = !idx_ok;
         C_OUT_FREE:  cond_hit = out_free;
         default:     cond_hit = 1'b1;
      endcase
   end

   always_comb begin
      pc_in        = cond_hit ? uw.jump_t : uw.jump_f;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      at_in        = at_ff;
      colq_in      = colq_ff;
      lineq_in     = lineq_ff;
      idx_in       = idx_ff;
      err_in       = err_ff;
      rch_in       = rch_ff;
      rat_in       = rat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = 16'd0;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff + AW'(COLUMNS);

      if (uw.cond == C_DISPATCH) begin
         pc_in = S_IDLE;
         if (req_acc) begin
            pc_in    = op_entry(req_tuser);
            op_in    = req_tuser;
            ch_in    = req_tdata[7:0];
            at_in    = req_tdata[15:8];
            colq_in  = req_tdata[22:16];
            lineq_in = req_tdata[27:23];
            idx_in   = req_tdata[38:28];
            cnt_in   = '0;
            err_in   = 1'b0;
            rch_in   = 8'd0;
            rat_in   = 8'd0;
         end
      end

      case (uw.act)
         A_NOP: begin
         end
         A_PUT: begin
            wr_en   = p_wr;
            wr_addr = p_addr;
            wr_data = p_data;
            err_in  = tgt_bad;
            row_in  = p_scroll ? RW'(ROWS - 1) : RW'(p_row1);
            col_in  = p_col;
         end
         A_BACK: begin
            wr_en   = 1'b1;
            wr_addr = b_addr;
            wr_data = {cattr_ff, CODE_SPACE};
            row_in  = b_row;
            col_in  = b_col;
         end
         A_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = {cattr_ff, CODE_SPACE};
            cnt_in  = cnt_ff + AW'(1);
            row_in  = '0;
            col_in  = '0;
         end
         A_READ: begin
            rd_en   = idx_ok;
            rd_addr = AW'(idx_ff);
            err_in  = !idx_ok;
         end
         A_CAPTURE: begin
            rch_in = rd_data[7:0];
            rat_in = rd_data[15:8];
         end
         A_SCR_RD: begin
            rd_en = 1'b1;
         end
         A_SCR_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            cnt_in  = cnt_ff + AW'(1);
         end
         A_ZERO: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + AW'(1);
         end
         A_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, err_ff, rat_ff, rch_ff, cur_x[10:0]};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sub_in   = sub_ff;
      eattr_in = eattr_ff;
      cattr_in = cattr_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_ZERO_ATTR_SUB: sub_in   = csr_pwdata[7:0];
            REG_ERROR_ATTR:    eattr_in = csr_pwdata[7:0];
            REG_CLEAR_ATTR:    cattr_in = csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_ZERO_ATTR_SUB: csr_prdata = {24'd0, sub_ff};
         REG_ERROR_ATTR:    csr_prdata = {24'd0, eattr_ff};
         REG_CLEAR_ATTR:    csr_prdata = {24'd0, cattr_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= S_IDLE;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         sub_ff       <= RESET_ZERO_ATTR_SUB;
         eattr_ff     <= RESET_ERROR_ATTR;
         cattr_ff     <= RESET_CLEAR_ATTR;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sub_ff       <= sub_in;
         eattr_ff     <= eattr_in;
         cattr_ff     <= cattr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      at_ff       <= at_in;
      colq_ff     <= colq_in;
      lineq_ff    <= lineq_in;
      idx_ff      <= idx_in;
      err_ff      <= err_in;
      rch_ff      <= rch_in;
      rat_ff      <= rat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `TCW_ASSERT_CLK(a_dispatch_leaves_idle, req_acc |=> (pc_ff != S_IDLE),
      "accepted item did not start a program")
   `TCW_ASSERT_CLK(a_emit_loads_output, (uw.act == A_EMIT && out_free) |=> rsp_tvalid,
      "finished item not placed in output register")
   `TCW_ASSERT_CLK(a_cursor_in_range, (int'(row_ff) < ROWS) && (int'(col_ff) < COLUMNS),
      "cursor outside the screen")
   `TCW_ASSERT_CLK(a_write_in_range, wr_en |-> (int'(wr_addr) < CELLS),
      "cell write beyond the store")

endmodule

// ===== tb/sv/tb_text_console_writer.sv =====
// Self-checking testbench for the text console writer: ops, scroll, errors, registers.
`timescale 1ns / 1ps

module tb_text_console_writer;
   import tcw_pkg::*;

   localparam int COLUMNS         = 80;
   localparam int ROWS            = 25;
   localparam int CELLS           = COLUMNS * ROWS;
   localparam int INDEX_SPAN      = 2048;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int RANDOM_PHASES   = 4;
   localparam int ITEMS_PER_PHASE = 400;
   localparam int PRESSURE_ITEMS  = 12;
   localparam int PRESSURE_HOLD   = 600;
   localparam int TAIL_CYCLES     = 20;
   localparam logic [2:0] OP_LAST_CODE = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  ch;
      logic [7:0]  attr;
      logic [6:0]  col;
      logic [4:0]  row;
      logic [10:0] idx;
   } console_cmd_type;

   typedef struct packed {
      logic [10:0] cursor;
      logic [7:0]  rd_char;
      logic [7:0]  rd_attr;
      logic        err;
   } console_rsp_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // character, attribute, column, line, cell_index, pad
   logic [2:0]  req_tuser;   // op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // cursor_cell, read_char, read_attr, coord_error
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // console state mirror
   logic [15:0] screen_mem [CELLS];
   bit          screen_known [CELLS];
   int          cursor_pos = 0;
   logic [7:0]  sub_attr_reg = RESET_ZERO_ATTR_SUB;
   logic [7:0]  err_attr_reg = RESET_ERROR_ATTR;
   logic [7:0]  clr_attr_reg = RESET_CLEAR_ATTR;

   console_rsp_type pending_reports [$];

   int  errors        = 0;
   int  items_sent    = 0;
   int  reports_seen  = 0;
   int  scroll_count  = 0;
   int  clear_count   = 0;
   int  coord_errors  = 0;
   int  reg_settings  = 0;
   int  quiet_cycles  = 0;
   int  hold_request  = 0;
   bit  src_gaps      = 1'b0;
   bit  sink_stalls   = 1'b0;

   text_console_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void store_cell(input int pos, input logic [7:0] ch,
                                      input logic [7:0] attr);
      screen_mem[pos]   = {attr, ch};
      screen_known[pos] = 1'b1;
   endfunction

   function automatic void scroll_rows();
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
         screen_mem[i]   = screen_mem[i + COLUMNS];
         screen_known[i] = screen_known[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
         store_cell(i, 8'h00, 8'h00);
      end
      scroll_count++;
   endfunction

   function automatic void place_char(input int start, input logic [7:0] ch,
                                      input logic [7:0] attr);
      int         pos;
      logic [7:0] a;
      pos = start;
      a   = (attr == 8'h00) ? sub_attr_reg : attr;
      if (ch == CODE_NEWLINE) begin
         pos = (pos / COLUMNS + 1) * COLUMNS;
      end else if (ch == CODE_BLANK_IN_PLACE) begin
         store_cell(pos, CODE_SPACE, a);
      end else begin
         store_cell(pos, ch, a);
         pos++;
      end
      if (pos >= CELLS) begin
         scroll_rows();
         pos -= COLUMNS;
      end
      cursor_pos = pos;
   endfunction

   function automatic console_rsp_type console_step(input console_cmd_type c);
      console_rsp_type r;
      r = '0;
      case (c.op)
         OP_PUT_CURSOR: place_char(cursor_pos, c.ch, c.attr);
         OP_PUT_AT: begin
            if (c.col >= COLUMNS || c.row >= ROWS) begin
               store_cell(CELLS - 1, CODE_ERROR, err_attr_reg);
               r.err = 1'b1;
               coord_errors++;
            end else begin
               place_char(int'(c.row) * COLUMNS + int'(c.col), c.ch, c.attr);
            end
         end
         OP_BACKSPACE: begin
            if (cursor_pos > 0) cursor_pos--;
            store_cell(cursor_pos, CODE_SPACE, clr_attr_reg);
         end
         OP_CLEAR: begin
            for (int i = 0; i < CELLS; i++) store_cell(i, CODE_SPACE, clr_attr_reg);
            cursor_pos = 0;
            clear_count++;
         end
         OP_READ: begin
            if (c.idx < CELLS) begin
               r.rd_char = screen_mem[c.idx][7:0];
               r.rd_attr = screen_mem[c.idx][15:8];
            end else begin
               r.err = 1'b1;
               coord_errors++;
            end
         end
         default: ;
      endcase
      r.cursor = cursor_pos[10:0];
      return r;
   endfunction

   function automatic console_cmd_type make_cmd(input logic [2:0] op, input int ch,
                                                input int attr, input int col,
                                                input int row, input int idx);
      console_cmd_type c;
      c.op   = op;
      c.ch   = ch[7:0];
      c.attr = attr[7:0];
      c.col  = col[6:0];
      c.row  = row[4:0];
      c.idx  = idx[10:0];
      return c;
   endfunction

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   // in-range picks are only cells with defined contents; some picks lie past the screen
   function automatic int pick_read_index();
      int r;
      int k;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(CELLS, INDEX_SPAN - 1);
      if (r < 40 && cursor_pos > 0 && screen_known[cursor_pos - 1]) return cursor_pos - 1;
      for (int t = 0; t < 16; t++) begin
         k = $urandom_range(0, CELLS - 1);
         if (screen_known[k]) return k;
      end
      return $urandom_range(CELLS, INDEX_SPAN - 1);
   endfunction

   function automatic console_cmd_type random_cmd();
      console_cmd_type c;
      int r;
      c = make_cmd(OP_PUT_CURSOR, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 127), $urandom_range(0, 31),
                   $urandom_range(0, INDEX_SPAN - 1));
      r = $urandom_range(0, 99);
      if (r < 8) c.ch = CODE_NEWLINE;
      else if (r < 13) c.ch = CODE_BLANK_IN_PLACE;
      if ($urandom_range(0, 9) == 0) c.attr = 8'h00;
      r = $urandom_range(0, 199);
      if (r < 90) begin
         c.op = OP_PUT_CURSOR;
      end else if (r < 140) begin
         c.op = OP_PUT_AT;
         r = $urandom_range(0, 99);
         if (r >= 12) begin
            c.col = 7'($urandom_range(0, COLUMNS - 1));
            c.row = (r < 30) ? 5'(ROWS - 1) : 5'($urandom_range(0, ROWS - 1));
         end
      end else if (r < 156) begin
         c.op = OP_BACKSPACE;
      end else if (r < 158) begin
         c.op = OP_CLEAR;
      end else if (r < 192) begin
         c.op  = OP_READ;
         c.idx = 11'(pick_read_index());
      end else begin
         c.op = 3'($urandom_range(OP_READ + 1, OP_LAST_CODE));
      end
      return c;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic send_item(input console_cmd_type c);
      int gap;
      req_tuser  = c.op;
      req_tdata  = {1'b0, c.idx, c.row, c.col, c.attr, c.ch};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_reports.push_back(console_step(c));
      items_sent++;
      @(negedge clock);
      gap = src_gaps ? idle_length() : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
   endtask

   task automatic read_register(input logic [1:0] index, input logic [7:0] want);
      csr_paddr   = {index, 2'b00};
      csr_pwrite  = 1'b0;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("register read", int'(want), int'(csr_prdata[7:0]));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic write_register(input logic [1:0] index, input logic [7:0] value);
      csr_paddr   = {index, 2'b00};
      csr_pwrite  = 1'b1;
      csr_pwdata  = {24'($urandom_range(0, 16777215)), value};
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_ZERO_ATTR_SUB: sub_attr_reg = value;
         REG_ERROR_ATTR:    err_attr_reg = value;
         REG_CLEAR_ATTR:    clr_attr_reg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_penable = 1'b0;
      csr_psel    = 1'b0;
      @(negedge clock);
      read_register(index, value);
   endtask

   task automatic set_attributes(input logic [7:0] sub, input logic [7:0] bad,
                                 input logic [7:0] clr);
      write_register(REG_ZERO_ATTR_SUB, sub);
      write_register(REG_ERROR_ATTR, bad);
      write_register(REG_CLEAR_ATTR, clr);
      reg_settings++;
   endtask

   task automatic test_reset_values();
      read_register(REG_ZERO_ATTR_SUB, RESET_ZERO_ATTR_SUB);
      read_register(REG_ERROR_ATTR, RESET_ERROR_ATTR);
      read_register(REG_CLEAR_ATTR, RESET_CLEAR_ATTR);
   endtask

   task automatic test_directed_ops();
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      send_item(make_cmd(OP_BACKSPACE, 'hA5, 'h5A, 0, 0, 0));      // at cell 0
      send_item(make_cmd(OP_READ, 0, 0, 0, 0, 0));
      send_item(make_cmd(OP_PUT_CURSOR, 'h41, 'h00, 0, 0, 0));     // substitute attr
      send_item(make_cmd(OP_PUT_CURSOR, int'(CODE_BLANK_IN_PLACE), 'h55, 0, 0, 0));
      send_item(make_cmd(OP_READ, 0, 0, 0, 0, 1));
      send_item(make_cmd(OP_PUT_CURSOR, int'(CODE_NEWLINE), 'h12, 0, 0, 0));
      send_item(make_cmd(OP_PUT_CURSOR, 'hFF, 'hFF, 127, 31, 2047));
      send_item(make_cmd(OP_PUT_AT, 'h00, 'h01, COLUMNS - 1, 0, 0));
      send_item(make_cmd(OP_PUT_AT, 'h78, 'h33, COLUMNS, 0, 0));
      send_item(make_cmd(OP_PUT_AT, 'h79, 'h33, 127, 31, 0));
      send_item(make_cmd(OP_PUT_AT, 'h7A, 'h33, 0, ROWS, 0));
      send_item(make_cmd(OP_READ, 0, 0, 0, 0, CELLS - 1));
      send_item(make_cmd(OP_READ, 0, 0, 0, 0, CELLS));
      send_item(make_cmd(OP_READ, 0, 0, 0, 0, INDEX_SPAN - 1));
      send_item(make_cmd(OP_READ, 0, 0, 0, 0, COLUMNS - 1));
      send_item(make_cmd(OP_READ, 0, 0, 0, 0, COLUMNS));
      for (int k = OP_READ + 1; k <= OP_LAST_CODE; k++) begin
         send_item(make_cmd(3'(k), 'hFF, 'hFF, 127, 31, 2047));
      end
      send_item(make_cmd(OP_BACKSPACE, 0, 0, 0, 0, 0));
      send_item(make_cmd(OP_CLEAR, 'hFF, 'hFF, 127, 31, 2047));
      send_item(make_cmd(OP_READ, 0, 0, 0, 0, 1234));
      wait_drained();
   endtask

   task automatic test_scroll_edges();
      send_item(make_cmd(OP_PUT_AT, 'h5A, 'h70, COLUMNS - 1, ROWS - 1, 0));
      send_item(make_cmd(OP_READ, 0, 0, 0, 0, CELLS - COLUMNS - 1));
      send_item(make_cmd(OP_READ, 0, 0, 0, 0, CELLS - 1));
      send_item(make_cmd(OP_PUT_AT, int'(CODE_NEWLINE), 'h00, 5, ROWS - 1, 0));
      send_item(make_cmd(OP_PUT_CURSOR, int'(CODE_BLANK_IN_PLACE), 'h00, 0, 0, 0));
      send_item(make_cmd(OP_BACKSPACE, 0, 0, 0, 0, 0));
      wait_drained();
   endtask

   // output held off while input keeps offering items
   task automatic test_output_backpressure();
      src_gaps     = 1'b0;
      sink_stalls  = 1'b0;
      hold_request = PRESSURE_HOLD;
      repeat (PRESSURE_ITEMS) send_item(random_cmd());
      wait_drained();
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       set_attributes(8'h00, 8'h00, 8'h00);
            1:       set_attributes(8'hFF, 8'hFF, 8'hFF);
            default: set_attributes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
         endcase
         src_gaps    = (ph != 2);
         sink_stalls = (ph != 2) && (ph != 3);
         repeat (ITEMS_PER_PHASE) send_item(random_cmd());
         wait_drained();
      end
   endtask

   initial begin : sink_ctl
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            n            = hold_request;
            hold_request = 0;
            rsp_tready   = 1'b0;
            repeat (n) @(negedge clock);
         end
         if (!sink_stalls || $urandom_range(0, 2) != 0) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b0;
            n = idle_length();
            repeat (n) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_reports
      console_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         reports_seen++;
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            check_field("cursor_cell", int'(want.cursor), int'(rsp_tdata[10:0]));
            check_field("read_char", int'(want.rd_char), int'(rsp_tdata[18:11]));
            check_field("read_attr", int'(want.rd_attr), int'(rsp_tdata[26:19]));
            check_field("coord_error", int'(want.err), int'(rsp_tdata[27]));
         end
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, pending_reports.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < CELLS; i++) begin
         screen_mem[i]   = '0;
         screen_known[i] = 1'b0;
      end
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_values();
      test_directed_ops();
      test_scroll_edges();
      test_output_backpressure();
      test_random_phases();

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Run covered %0d items and %0d results under %0d register settings.",
               items_sent, reports_seen, reg_settings + 1);
      $display("Scrolls %0d, clears %0d, bad coordinates %0d, mismatches %0d.",
               scroll_count, clear_count, coord_errors, errors);
      if (errors == 0 && pending_reports.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== text_console_writer.f =====
+incdir+hdl
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/text_console_writer.sv
tb/sv/tb_text_console_writer.sv
